// File: hdl/rgbo_pkg.sv
// rgbo_pkg: pixel request types, divider lane types and shared constants
// for the rgba over compositor; no dependencies
package rgbo_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned LANES      = 3;
  localparam int unsigned NUM_W      = 17;
  localparam int unsigned DEN_W      = 9;
  localparam int unsigned PROD_W     = 16;
  localparam int unsigned DIV_STAGES = CH_W;

  localparam logic [CH_W-1:0] CH_MAX = 8'hff;

  typedef struct packed {
    logic [CH_W-1:0] src_red;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] src_alpha;
    logic [CH_W-1:0] dst_red;
    logic [CH_W-1:0] dst_green;
    logic [CH_W-1:0] dst_blue;
    logic [CH_W-1:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } pix_out_t;

  // one request in flight through the divider, lane 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][CH_W-1:0]  quo;
    logic [DEN_W-1:0]            den;
    logic                        byp;
    logic [LANES-1:0][CH_W-1:0]  dst;
    logic [CH_W-1:0]             alpha;
  } div_t;

  // truncating x / 255, exact for x up to 255 * 255
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + {9'd0, x[PROD_W-1:CH_W]} + 17'd1;
    return sum[PROD_W-1:CH_W];
  endfunction

endpackage

// File: hdl/rgba_over_compositor_unit.sv
// rgba_over_compositor_unit: straight-alpha over blend of rgba8 pixels
// depends on rgbo_pkg and rgbo_divider
//
// Takes one source/destination pixel pair per clock and returns one blended
// pixel per clock while the output is not stalled. Three stages form the
// destination weight, the blended alpha and the per-channel numerators and
// divisor; the remaining eight are a restoring divider that resolves one
// quotient bit per stage for the red, green and blue lanes side by side. A
// fully transparent source passes the destination pixel through the same
// pipe. Stalls propagate back stage by stage, so bubbles are squeezed out
// before the input is stalled.
module rgba_over_compositor_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  rgbo_pkg::pix_in_t  in_pix_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output rgbo_pkg::pix_out_t out_pix_o,
  input  logic               out_stall_i
);
  import rgbo_pkg::*;

  typedef struct packed {
    logic [LANES-1:0][CH_W-1:0] src;
    logic [LANES-1:0][CH_W-1:0] dst;
    logic [CH_W-1:0]            sa;
    logic [CH_W-1:0]            da;
    logic [PROD_W-1:0]          prod_w;
    logic [PROD_W-1:0]          prod_al;
    logic                       byp;
  } s1_t;

  typedef struct packed {
    logic [LANES-1:0][CH_W-1:0] src;
    logic [LANES-1:0][CH_W-1:0] dst;
    logic [CH_W-1:0]            sa;
    logic [CH_W-1:0]            w;
    logic [CH_W-1:0]            al;
    logic                       byp;
  } s2_t;

  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  div_t s3_q, s3_d;
  logic v1_q, v2_q, v3_q;
  logic ld1, ld2, ld3;

  logic div_stall;
  logic div_valid;
  div_t div_out;

  assign ld3        = !v3_q || !div_stall;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_stall_o = !ld1;

  // weight and alpha products
  always_comb begin
    s1_d.src     = {in_pix_i.src_blue, in_pix_i.src_green, in_pix_i.src_red};
    s1_d.dst     = {in_pix_i.dst_blue, in_pix_i.dst_green, in_pix_i.dst_red};
    s1_d.sa      = in_pix_i.src_alpha;
    s1_d.da      = in_pix_i.dst_alpha;
    s1_d.prod_w  = PROD_W'(in_pix_i.dst_alpha) * PROD_W'(CH_MAX - in_pix_i.src_alpha);
    s1_d.prod_al = PROD_W'(in_pix_i.src_alpha) * PROD_W'(CH_MAX - in_pix_i.dst_alpha);
    s1_d.byp     = (in_pix_i.src_alpha == '0);
  end

  // divide by 255
  always_comb begin
    s2_d.src = s1_q.src;
    s2_d.dst = s1_q.dst;
    s2_d.sa  = s1_q.sa;
    s2_d.w   = div255(s1_q.prod_w);
    s2_d.al  = s1_q.da + div255(s1_q.prod_al);
    s2_d.byp = s1_q.byp;
  end

  // numerators and divisor
  always_comb begin
    logic [PROD_W-1:0] ps;
    logic [PROD_W-1:0] pd;
    s3_d = '0;
    for (int c = 0; c < LANES; c++) begin
      ps          = PROD_W'(s2_q.src[c]) * PROD_W'(s2_q.sa);
      pd          = PROD_W'(s2_q.dst[c]) * PROD_W'(s2_q.w);
      s3_d.rem[c] = NUM_W'(ps) + NUM_W'(pd);
    end
    s3_d.den   = DEN_W'(s2_q.sa) + DEN_W'(s2_q.w);
    s3_d.byp   = s2_q.byp;
    s3_d.dst   = s2_q.dst;
    s3_d.alpha = s2_q.al;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_q <= s1_d;
    end
    if (ld2) begin
      s2_q <= s2_d;
    end
    if (ld3) begin
      s3_q <= s3_d;
    end
  end

  rgbo_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_req_i    (s3_q),
    .in_stall_o  (div_stall),
    .out_valid_o (div_valid),
    .out_req_o   (div_out),
    .out_stall_i (out_stall_i)
  );

  assign out_valid_o         = div_valid;
  assign out_pix_o.out_red   = div_out.byp ? div_out.dst[0] : div_out.quo[0];
  assign out_pix_o.out_green = div_out.byp ? div_out.dst[1] : div_out.quo[1];
  assign out_pix_o.out_blue  = div_out.byp ? div_out.dst[2] : div_out.quo[2];
  assign out_pix_o.out_alpha = div_out.alpha;

endmodule

// File: hdl/rgbo_divider.sv
// rgbo_divider: three-lane restoring divider, one quotient bit per stage
// depends on rgbo_pkg
module rgbo_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rgbo_pkg::div_t in_req_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output rgbo_pkg::div_t out_req_o,
  input  logic          out_stall_i
);
  import rgbo_pkg::*;

  localparam int unsigned LAST = DIV_STAGES - 1;

  div_t                  st_q [DIV_STAGES];
  div_t                  st_d [DIV_STAGES];
  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_STAGES-1:0] prev_v;
  logic [DIV_STAGES-1:0] ld;

  always_comb begin
    ld[LAST] = !v_q[LAST] || !out_stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int unsigned BIT = DIV_STAGES - 1 - k;
    div_t prev;
    if (k == 0) begin : g_first
      assign prev      = in_req_i;
      assign prev_v[k] = in_valid_i;
    end else begin : g_next
      assign prev      = st_q[k-1];
      assign prev_v[k] = v_q[k-1];
    end

    always_comb begin
      logic [NUM_W-1:0] dv;
      dv       = NUM_W'(prev.den) << BIT;
      st_d[k]  = prev;
      for (int c = 0; c < LANES; c++) begin
        if (prev.rem[c] >= dv) begin
          st_d[k].rem[c]      = prev.rem[c] - dv;
          st_d[k].quo[c][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ld[k]) begin
        v_q[k] <= prev_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v_q[LAST];
  assign out_req_o   = st_q[LAST];

  // remainder below divisor once all quotient bits are resolved
  a_rem_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAST] && !st_q[LAST].byp) |->
      (st_q[LAST].rem[0] < NUM_W'(st_q[LAST].den)))
    else $error("red remainder not below divisor");

  a_rem_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAST] && !st_q[LAST].byp) |->
      (st_q[LAST].rem[2] < NUM_W'(st_q[LAST].den)))
    else $error("blue remainder not below divisor");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("stall raised with a bubble in the pipe");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && !in_stall_o) && out_valid_o && out_stall_i) |=>
      ($countones(v_q) == $past($countones(v_q))))
    else $error("request lost or created in the pipe");

endmodule
